// File: hdl/double_hash_table_insert_lookup_assert.svh
// Assertion macros used by the checker of the hash table block.
`ifndef DOUBLE_HASH_TABLE_INSERT_LOOKUP_ASSERT_SVH
`define DOUBLE_HASH_TABLE_INSERT_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on clock and switched off while reset is high.
`define DHTIL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and switched off while reset is high.
`define DHTIL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/dhtil_pkg.sv
// Package with field widths, codes and controller/datapath structs of the hash table.
package dhtil_pkg;

   localparam int ID_W     = 31;
   localparam int HANDLE_W = 16;
   localparam int INDEX_W  = 10;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_INSERTED  = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic       clear_en;
      logic       load_item;
      logic       div_run;
      logic       save_home;
      logic       save_stepmod;
      logic       probe_start;
      logic       advance;
      logic       write_slot;
      logic       finish;
      status_type result_status;
      logic       push;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_last;
      logic step_fits;
      logic is_insert;
      logic slot_valid;
      logic key_match;
      logic count_full;
      logic next_is_home;
      logic out_free;
   } dp_status_type;

endpackage

// File: hdl/dhtil_if.sv
// Request and response channel interfaces of the hash table.
interface dhtil_req_if import dhtil_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                command;
   logic [ID_W-1:0]     cust_id;
   logic [HANDLE_W-1:0] record_handle;

   modport source (output valid, output command, output cust_id, output record_handle,
                   input ready);
   modport sink (input valid, input command, input cust_id, input record_handle,
                 output ready);
endinterface

interface dhtil_rsp_if import dhtil_pkg::*; ();
   logic                valid;
   logic                ready;
   status_type          status;
   logic [INDEX_W-1:0]  slot_index;
   logic [HANDLE_W-1:0] found_handle;

   modport source (output valid, output status, output slot_index, output found_handle,
                   input ready);
   modport sink (input valid, input status, input slot_index, input found_handle,
                 output ready);
endinterface

// File: hdl/dhtil_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dhtil_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/dhtil_ctrl.sv
// Controller state machine sequencing clear, remainder passes and probes.
module dhtil_ctrl import dhtil_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_ID,
      S_HOME,
      S_DIV_STEP,
      S_SAVE_STEP,
      S_START,
      S_CHECK,
      S_REPLY
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DIV_ID;
            end
         end
         S_DIV_ID: begin
            cmd.div_run = 1'b1;
            if (status.div_last) begin
               state_in = S_HOME;
            end
         end
         S_HOME: begin
            cmd.save_home = 1'b1;
            state_in      = status.step_fits ? S_START : S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.div_run = 1'b1;
            if (status.div_last) begin
               state_in = S_SAVE_STEP;
            end
         end
         S_SAVE_STEP: begin
            cmd.save_stepmod = 1'b1;
            state_in         = S_START;
         end
         S_START: begin
            cmd.probe_start = 1'b1;
            state_in        = S_CHECK;
         end
         S_CHECK: begin
            if (status.is_insert) begin
               if (!status.slot_valid) begin
                  cmd.write_slot    = 1'b1;
                  cmd.finish        = 1'b1;
                  cmd.result_status = STATUS_INSERTED;
                  state_in          = S_REPLY;
               end else if (status.count_full) begin
                  cmd.finish        = 1'b1;
                  cmd.result_status = STATUS_FULL;
                  state_in          = S_REPLY;
               end else begin
                  cmd.advance = 1'b1;
               end
            end else begin
               if (status.count_full) begin
                  cmd.finish        = 1'b1;
                  cmd.result_status = STATUS_NOT_FOUND;
                  state_in          = S_REPLY;
               end else if (status.slot_valid && status.key_match) begin
                  cmd.finish        = 1'b1;
                  cmd.result_status = STATUS_FOUND;
                  state_in          = S_REPLY;
               end else if (status.next_is_home) begin
                  // The probe sequence has wrapped round to the home slot.
                  cmd.finish        = 1'b1;
                  cmd.result_status = STATUS_NOT_FOUND;
                  state_in          = S_REPLY;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         S_REPLY: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// File: hdl/dhtil_dp.sv
// Datapath: remainder unit, probe address generator, slot stores and result registers.
module dhtil_dp import dhtil_pkg::*; #(
   parameter int SLOTS        = 1021,
   parameter int STEP_MODULUS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic                req_command,
   input  logic [ID_W-1:0]     req_cust_id,
   input  logic [HANDLE_W-1:0] req_record_handle,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output status_type          rsp_status,
   output logic [INDEX_W-1:0]  rsp_slot_index,
   output logic [HANDLE_W-1:0] rsp_found_handle
);

   localparam int NW     = $clog2(SLOTS);
   localparam int CW     = $clog2(SLOTS + 1);
   localparam int RW     = $clog2(STEP_MODULUS);
   localparam int SW     = $clog2(STEP_MODULUS + 1);
   localparam int KW     = ID_W + HANDLE_W;
   localparam int SN     = ID_W + NW;
   localparam int SR     = ID_W + RW;
   localparam int PW     = ID_W + 32;

   localparam longint unsigned MulNFull =
      ((64'd1 << SN) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
   localparam longint unsigned MulRFull =
      ((64'd1 << SR) + 64'(STEP_MODULUS) - 64'd1) / 64'(STEP_MODULUS);

   localparam logic [NW:0]   NMod     = (NW + 1)'(SLOTS);
   localparam logic [NW-1:0] NLow     = NW'(SLOTS);
   localparam logic [RW-1:0] RLow     = RW'(STEP_MODULUS);
   localparam logic [31:0]   MulN     = 32'(MulNFull);
   localparam logic [31:0]   MulR     = 32'(MulRFull);
   localparam logic          StepFits = (STEP_MODULUS < SLOTS);

   logic                cmd_ff;
   logic [ID_W-1:0]     id_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [ID_W-1:0]     div_ff;
   logic [ID_W-1:0]     quo_n_ff, quo_n_in;
   logic [ID_W-1:0]     quo_r_ff, quo_r_in;
   logic [NW-1:0]       rem_n_ff, rem_n_in;
   logic [RW-1:0]       rem_r_ff, rem_r_in;
   logic                div_cnt_ff;
   logic [NW-1:0]       home_ff, stepmod_ff, cur_ff, nxt_ff;
   logic [CW-1:0]       count_ff;
   logic [NW-1:0]       clr_ff;
   status_type          res_status_ff;
   logic [INDEX_W-1:0]  res_index_ff;
   logic [HANDLE_W-1:0] res_handle_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          out_status_ff;
   logic [INDEX_W-1:0]  out_index_ff;
   logic [HANDLE_W-1:0] out_handle_ff;

   logic [PW-1:0]       prod_n, prod_r;
   logic [SW-1:0]       step_c;
   logic [NW-1:0]       probe_base, probe_next;
   logic [NW:0]         probe_sum;
   logic                v_rd;
   logic [KW-1:0]       kh_rd;
   logic                v_wr_en, ram_rd_en;
   logic [NW-1:0]       v_wr_addr;
   logic                out_free, hit_result;

   // Remainders by reciprocal multiplication: the first step registers the quotients, the
   // second takes the remainders from the low bits, as each lies below its modulus.
   assign prod_n   = {32'd0, div_ff} * {{ID_W{1'b0}}, MulN};
   assign prod_r   = {32'd0, div_ff} * {{ID_W{1'b0}}, MulR};
   assign quo_n_in = ID_W'(prod_n >> SN);
   assign quo_r_in = ID_W'(prod_r >> SR);
   assign rem_n_in = div_ff[NW-1:0] - quo_n_ff[NW-1:0] * NLow;
   assign rem_r_in = div_ff[RW-1:0] - quo_r_ff[RW-1:0] * RLow;

   assign step_c = SW'(STEP_MODULUS) - SW'(rem_r_ff);

   // Both operands are below SLOTS, so one conditional subtract closes the modulo.
   assign probe_base = cmd.probe_start ? home_ff : nxt_ff;
   assign probe_sum  = {1'b0, probe_base} + {1'b0, stepmod_ff};
   assign probe_next = (probe_sum >= NMod) ? NW'(probe_sum - NMod) : probe_sum[NW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cmd_ff     <= req_command;
         id_ff      <= req_cust_id;
         handle_ff  <= req_record_handle;
         div_ff     <= req_cust_id;
         rem_n_ff   <= '0;
         rem_r_ff   <= '0;
         div_cnt_ff <= 1'b0;
      end else if (cmd.div_run) begin
         quo_n_ff   <= quo_n_in;
         quo_r_ff   <= quo_r_in;
         rem_n_ff   <= rem_n_in;
         rem_r_ff   <= rem_r_in;
         div_cnt_ff <= 1'b1;
      end else if (cmd.save_home) begin
         // The second pass, when needed, reduces the step modulo SLOTS.
         home_ff    <= rem_n_ff;
         stepmod_ff <= NW'(step_c);
         div_ff     <= ID_W'(step_c);
         rem_n_ff   <= '0;
         rem_r_ff   <= '0;
         div_cnt_ff <= 1'b0;
      end else if (cmd.save_stepmod) begin
         stepmod_ff <= rem_n_ff;
      end
      if (cmd.probe_start) begin
         cur_ff   <= home_ff;
         nxt_ff   <= probe_next;
         count_ff <= CW'(1);
      end else if (cmd.advance) begin
         cur_ff   <= nxt_ff;
         nxt_ff   <= probe_next;
         count_ff <= count_ff + CW'(1);
      end
      if (cmd.finish) begin
         res_status_ff <= cmd.result_status;
         res_index_ff  <= hit_result ? INDEX_W'(cur_ff) : '0;
         res_handle_ff <= (cmd.result_status == STATUS_FOUND) ? kh_rd[HANDLE_W-1:0] : '0;
      end
      if (cmd.push) begin
         out_status_ff <= res_status_ff;
         out_index_ff  <= res_index_ff;
         out_handle_ff <= res_handle_ff;
      end
   end

   assign hit_result = (cmd.result_status == STATUS_FOUND) ||
                       (cmd.result_status == STATUS_INSERTED);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            clr_ff <= clr_ff + NW'(1);
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign v_wr_en   = cmd.clear_en || cmd.write_slot;
   assign v_wr_addr = cmd.clear_en ? clr_ff : cur_ff;
   assign ram_rd_en = cmd.probe_start || cmd.advance;

   dhtil_ram #(
      .WIDTH(1),
      .DEPTH(SLOTS)
   ) u_valid_ram (
      .clock  (clock),
      .wr_en  (v_wr_en),
      .wr_addr(v_wr_addr),
      .wr_data(cmd.write_slot),
      .rd_en  (ram_rd_en),
      .rd_addr(probe_base),
      .rd_data(v_rd)
   );

   dhtil_ram #(
      .WIDTH(KW),
      .DEPTH(SLOTS)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (cmd.write_slot),
      .wr_addr(cur_ff),
      .wr_data({id_ff, handle_ff}),
      .rd_en  (ram_rd_en),
      .rd_addr(probe_base),
      .rd_data(kh_rd)
   );

   always_comb begin
      status              = '0;
      status.clear_last   = (clr_ff == NW'(SLOTS - 1));
      status.div_last     = div_cnt_ff;
      status.step_fits    = StepFits;
      status.is_insert    = (cmd_ff == CMD_INSERT);
      status.slot_valid   = v_rd;
      status.key_match    = (kh_rd[KW-1:HANDLE_W] == id_ff);
      status.count_full   = (count_ff == CW'(SLOTS));
      status.next_is_home = (nxt_ff == home_ff);
      status.out_free     = out_free;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_slot_index   = out_index_ff;
   assign rsp_found_handle = out_handle_ff;

endmodule

// File: hdl/double_hash_table_insert_lookup.sv
// Top level of the double-hashing hash table with insert and lookup.
//
//   channel   direction  handshake      contents
//   req_port  in         valid/ready    command, cust_id, record_handle
//   rsp_port  out        valid/ready    status, slot_index, found_handle
//
// An item is loaded, its key divided and its home slot saved; if STEP_MODULUS is not below
// SLOTS the step is divided and saved too; then slots are probed up to the reply. The home
// slot and step come from a remainder unit that multiplies by a reciprocal; each probe
// costs one read of the slot RAMs. After reset the valid store is swept to vacant, one slot
// a cycle; no item is taken meanwhile. The result sits in an output register; while it is
// stalled the next item runs up to its reply and waits there, and no further item is taken.
module double_hash_table_insert_lookup import dhtil_pkg::*; #(
   parameter int SLOTS        = 1021,
   parameter int STEP_MODULUS = 7
) (
   input logic        clock,
   input logic        reset,
   dhtil_req_if.sink   req_port,
   dhtil_rsp_if.source rsp_port
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   dhtil_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_port.valid),
      .req_ready(req_port.ready),
      .status   (status),
      .cmd      (cmd)
   );

   dhtil_dp #(
      .SLOTS       (SLOTS),
      .STEP_MODULUS(STEP_MODULUS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_command      (req_port.command),
      .req_cust_id      (req_port.cust_id),
      .req_record_handle(req_port.record_handle),
      .rsp_ready        (rsp_port.ready),
      .rsp_valid        (rsp_port.valid),
      .rsp_status       (rsp_port.status),
      .rsp_slot_index   (rsp_port.slot_index),
      .rsp_found_handle (rsp_port.found_handle)
   );

endmodule

// File: hdl/dhtil_checker.sv
// Port-level checker for the hash table and its bind to the top level.
`include "double_hash_table_insert_lookup_assert.svh"

module dhtil_checker import dhtil_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input status_type          rsp_status,
   input logic [INDEX_W-1:0]  rsp_slot_index,
   input logic [HANDLE_W-1:0] rsp_found_handle
);

   // Items taken in whose results have not yet been delivered.
   logic [1:0] outstanding_ff;
   logic       req_acc, rsp_acc, rsp_stall;
   logic [INDEX_W+HANDLE_W+1:0] rsp_word;

   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_status, rsp_slot_index, rsp_found_handle};

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else if (req_acc && !rsp_acc) begin
         outstanding_ff <= outstanding_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         outstanding_ff <= outstanding_ff - 2'd1;
      end
   end

   `DHTIL_ASSERT_IMP(a_clear_after_reset, $past(reset), !req_ready, "item taken during clear")
   `DHTIL_ASSERT_IMP(a_rsp_has_item, rsp_valid, outstanding_ff != 2'd0, "result without item")
   `DHTIL_ASSERT_IMP(a_one_in_work, req_acc, outstanding_ff != 2'd2, "too many items in flight")
   `DHTIL_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "stalled result changed")

endmodule

bind double_hash_table_insert_lookup dhtil_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_status      (rsp_port.status),
   .rsp_slot_index  (rsp_port.slot_index),
   .rsp_found_handle(rsp_port.found_handle)
);

// File: sim/tb_top.sv
// Self-checking testbench of the double-hashing hash table: directed and random inserts and lookups.
`timescale 1ns / 1ps

module tb_top import dhtil_pkg::*; ();

   localparam int unsigned SLOTS      = 1021;
   localparam int unsigned STEP_MOD   = 7;
   localparam int unsigned CYCLE_CAP  = 10_000_000;
   localparam int unsigned TAIL_WAIT  = 40;
   localparam int unsigned PHASE_OPS  = 120;
   localparam int unsigned ID_SPAN    = 2_103_000;

   typedef struct {
      logic                cmd;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
   } table_op_type;

   typedef struct packed {
      status_type          status;
      logic [INDEX_W-1:0]  slot;
      logic [HANDLE_W-1:0] handle;
   } outcome_type;

   logic clock;
   logic reset;

   dhtil_req_if req_bus ();
   dhtil_rsp_if rsp_bus ();

   double_hash_table_insert_lookup #(
      .SLOTS        (SLOTS),
      .STEP_MODULUS (STEP_MOD)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Shadow copy of the slot store.
   bit                  shadow_valid [SLOTS];
   logic [ID_W-1:0]     shadow_key [SLOTS];
   logic [HANDLE_W-1:0] shadow_handle [SLOTS];

   table_op_type    pending_ops [$];
   outcome_type     awaited_outcomes [$];
   logic [ID_W-1:0] stored_ids [$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned cycle_count;
   int unsigned failures;
   int unsigned inserts_taken;
   int unsigned lookups_taken;
   int unsigned status_seen [4];

   function automatic outcome_type table_outcome(logic cmd, logic [ID_W-1:0] id,
                                                 logic [HANDLE_W-1:0] handle);
      int unsigned home;
      int unsigned stride;
      int unsigned idx;
      int unsigned count;
      outcome_type res;
      home   = id % SLOTS;
      stride = STEP_MOD - (id % STEP_MOD);
      idx    = home;
      res.status = STATUS_NOT_FOUND;
      res.slot   = '0;
      res.handle = '0;
      if (cmd == CMD_INSERT) begin
         for (count = 1; shadow_valid[idx]; count++) begin
            if (count == SLOTS) begin
               res.status = STATUS_FULL;
               return res;
            end
            idx = (home + count * stride) % SLOTS;
         end
         shadow_valid[idx]  = 1'b1;
         shadow_key[idx]    = id;
         shadow_handle[idx] = handle;
         res.status = STATUS_INSERTED;
         res.slot   = idx[INDEX_W-1:0];
         return res;
      end
      // A lookup walks past vacant slots and stops only on a match, on coming
      // back to the home slot, or when the probe count reaches the table size.
      for (count = 1; count < SLOTS; count++) begin
         if (shadow_valid[idx] && shadow_key[idx] == id) begin
            res.status = STATUS_FOUND;
            res.slot   = idx[INDEX_W-1:0];
            res.handle = shadow_handle[idx];
            return res;
         end
         idx = (home + count * stride) % SLOTS;
         if (idx == home) break;
      end
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.command       = CMD_LOOKUP;
      req_bus.cust_id       = '0;
      req_bus.record_handle = '0;
      rsp_bus.ready         = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Driver: holds an item until it is taken, then fetches the next one.
   always @(posedge clock) begin
      table_op_type op;
      bit           taken;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         taken = req_bus.valid && req_bus.ready;
         if (taken) begin
            awaited_outcomes.push_back(table_outcome(req_bus.command, req_bus.cust_id,
                                                     req_bus.record_handle));
            if (req_bus.command == CMD_INSERT) inserts_taken++;
            else lookups_taken++;
         end
         if (!req_bus.valid || taken) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               op = pending_ops.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.command       <= op.cmd;
               req_bus.cust_id       <= op.id;
               req_bus.record_handle <= op.handle;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: applies back-pressure and checks every result taken.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            status_seen[rsp_bus.status]++;
            if (awaited_outcomes.size() == 0) begin
               $error("unexpected result: status %0d, slot_index %0d, found_handle %0h",
                      rsp_bus.status, rsp_bus.slot_index, rsp_bus.found_handle);
               failures++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  failures++;
               end
               if (rsp_bus.slot_index !== want.slot) begin
                  $error("slot_index: expected %0d, got %0d", want.slot, rsp_bus.slot_index);
                  failures++;
               end
               if (rsp_bus.found_handle !== want.handle) begin
                  $error("found_handle: expected %0h, got %0h", want.handle,
                         rsp_bus.found_handle);
                  failures++;
               end
            end
         end
      end
   end

   task automatic push_op(logic cmd, logic [ID_W-1:0] id, logic [HANDLE_W-1:0] handle);
      table_op_type op;
      op.cmd    = cmd;
      op.id     = id;
      op.handle = handle;
      pending_ops.push_back(op);
      if (cmd == CMD_INSERT) begin
         stored_ids.push_back(id);
      end
   endtask

   // Returns a key that shares its home slot with a stored key but not its value, as a rule.
   function automatic logic [ID_W-1:0] colliding_id();
      logic [ID_W-1:0] base;
      base = stored_ids[$urandom_range(stored_ids.size() - 1)];
      return (base % SLOTS) + SLOTS * $urandom_range(ID_SPAN);
   endfunction

   task automatic add_random_op();
      logic [ID_W-1:0] id;
      int unsigned     sel;
      sel = $urandom_range(9);
      if ($urandom_range(99) < 45) begin
         if (sel < 4 || stored_ids.size() == 0) id = $urandom();
         else if (sel < 7) id = colliding_id();
         else if (sel < 9) id = stored_ids[$urandom_range(stored_ids.size() - 1)];
         else id = $urandom_range(3 * SLOTS);
         push_op(CMD_INSERT, id, $urandom());
      end else begin
         if (sel < 7 && stored_ids.size() != 0)
            id = stored_ids[$urandom_range(stored_ids.size() - 1)];
         else if (sel < 9 && stored_ids.size() != 0) id = colliding_id();
         else id = $urandom();
         push_op(CMD_LOOKUP, id, $urandom());
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_bus.valid || awaited_outcomes.size() != 0);
   endtask

   task automatic run_phase(int unsigned count, int unsigned send_pct, int unsigned stall_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      repeat (count) add_random_op();
      wait_drained();
   endtask

   initial begin
      while (cycle_count < CYCLE_CAP) @(posedge clock);
      $display("double_hash_table_insert_lookup test failed");
      $finish;
   end

   initial begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, key extremes, duplicates and shared home slots.
      push_op(CMD_LOOKUP, '0, 16'hFFFF);
      push_op(CMD_INSERT, '0, '0);
      push_op(CMD_INSERT, '1, 16'hFFFF);
      push_op(CMD_LOOKUP, '0, '0);
      push_op(CMD_LOOKUP, '1, 16'h5A5A);
      push_op(CMD_INSERT, 31'd5, 16'hAAAA);
      push_op(CMD_INSERT, 31'd5, 16'h5555);
      push_op(CMD_LOOKUP, 31'd5, '0);
      push_op(CMD_INSERT, 31'd3, 16'h0001);
      push_op(CMD_INSERT, 31'd3 + SLOTS, 16'h0002);
      push_op(CMD_INSERT, 31'd3 + 2 * SLOTS, 16'h0004);
      push_op(CMD_LOOKUP, 31'd3 + 2 * SLOTS, '0);
      push_op(CMD_LOOKUP, 31'd3 + SLOTS, '0);
      push_op(CMD_LOOKUP, 31'd3 + 5 * SLOTS, '0);
      push_op(CMD_INSERT, SLOTS - 1, 16'h8000);
      push_op(CMD_LOOKUP, SLOTS - 1, 16'h7FFF);
      push_op(CMD_INSERT, 31'h7FFF_FFFF - SLOTS, 16'h1234);
      push_op(CMD_LOOKUP, 31'h7FFF_FFFF - SLOTS, '0);
      wait_drained();

      run_phase(PHASE_OPS, 0, 0);
      run_phase(PHASE_OPS, 76, 0);
      run_phase(PHASE_OPS, 0, 76);
      run_phase(PHASE_OPS, 9, 9);
      run_phase(PHASE_OPS, 0, 0);

      repeat (TAIL_WAIT) @(posedge clock);
      $display("Ran %0d inserts and %0d lookups under free, idle, stalled and mixed handshakes.",
               inserts_taken, lookups_taken);
      $display("Results: %0d found, %0d not found, %0d inserted, %0d full.",
               status_seen[STATUS_FOUND], status_seen[STATUS_NOT_FOUND],
               status_seen[STATUS_INSERTED], status_seen[STATUS_FULL]);
      if (failures == 0 && awaited_outcomes.size() == 0) begin
         $display("double_hash_table_insert_lookup test passed");
      end else begin
         $display("double_hash_table_insert_lookup test failed");
      end
      $finish;
   end

endmodule
